[design/xcfp_pkg.sv]
// Shared types, character codes, result codes and keyword helpers for the
// framed command line checker. Used by every module in the design folder.
package xcfp_pkg;

    // Number of characters kept for the command and value fields.
    localparam int FIELD_CHARS = 8;
    localparam int FIELD_IDX_W = $clog2(FIELD_CHARS);

    // Longest keyword, in characters, and its packed width.
    localparam int KW_MAX  = 5;
    localparam int KW_BITS = 8 * KW_MAX;

    typedef logic [FIELD_CHARS-1:0][7:0] t_field;

    // One input item and one result item.
    typedef struct packed {
        logic [7:0] char_in;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         command;
        logic signed [15:0] value;
    } t_out_item;

    // Line state handed from the scanner to the verdict logic.
    typedef struct packed {
        logic        in_body;
        logic        closed;
        logic [1:0]  comma_count;
        logic [7:0]  payload_xor;
        logic [7:0]  hex_acc;
        logic        hex_neg;
        logic [3:0]  cmd_len;
        t_field      cmd_chars;
        logic [7:0]  val_len;
        t_field      val_chars;
        logic [15:0] num_acc;
        logic        num_neg;
    } t_line_state;

    // Character codes.
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_UC_X  = 8'h58;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_FRAME = 3'd1;
    localparam logic [2:0] ST_NO_COMMAS = 3'd2;
    localparam logic [2:0] ST_CHECKSUM  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    // Command codes.
    localparam logic [3:0] CMD_HOME  = 4'd0;
    localparam logic [3:0] CMD_READY = 4'd1;
    localparam logic [3:0] CMD_DROP  = 4'd2;
    localparam logic [3:0] CMD_WRIST = 4'd3;
    localparam logic [3:0] CMD_SOFT  = 4'd4;
    localparam logic [3:0] CMD_HARD  = 4'd5;
    localparam logic [3:0] CMD_OPEN  = 4'd6;
    localparam logic [3:0] CMD_STOP  = 4'd7;
    localparam logic [3:0] CMD_NONE  = 4'd8;

    // Keywords, right aligned in KW_BITS with their lengths.
    localparam logic [KW_BITS-1:0] KW_POSE  = KW_BITS'("POSE");
    localparam logic [KW_BITS-1:0] KW_HOME  = KW_BITS'("HOME");
    localparam logic [KW_BITS-1:0] KW_READY = KW_BITS'("READY");
    localparam logic [KW_BITS-1:0] KW_DROP  = KW_BITS'("DROP");
    localparam logic [KW_BITS-1:0] KW_WRIST = KW_BITS'("WRIST");
    localparam logic [KW_BITS-1:0] KW_GRIP  = KW_BITS'("GRIP");
    localparam logic [KW_BITS-1:0] KW_SOFT  = KW_BITS'("SOFT");
    localparam logic [KW_BITS-1:0] KW_HARD  = KW_BITS'("HARD");
    localparam logic [KW_BITS-1:0] KW_OPEN  = KW_BITS'("OPEN");
    localparam logic [KW_BITS-1:0] KW_STOP  = KW_BITS'("STOP");
    localparam logic [2:0] KW_LEN4 = 3'd4;
    localparam logic [2:0] KW_LEN5 = 3'd5;

    // True when the stored field has exactly the keyword's length and text.
    function automatic logic kw_match(input t_field chars, input logic [7:0] len,
                                      input logic [KW_BITS-1:0] kw,
                                      input logic [2:0] kw_len);
        logic [KW_BITS-1:0] kw_al;
        logic               same;
        kw_al = kw << (8 * (KW_MAX - int'(kw_len)));
        same  = (len == {5'd0, kw_len});
        for (int i = 0; i < KW_MAX; i++) begin
            if (i < int'(kw_len) && chars[i] != kw_al[KW_BITS-1-8*i -: 8]) begin
                same = 1'b0;
            end
        end
        return same;
    endfunction

    // Whitespace in the sense of the C library: space, tab through CR.
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Hex digit decode: bit 4 flags a valid digit, bits 3:0 give its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = {1'b1, 4'(c - CH_0)};
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            d = {1'b1, 4'(c - CH_LC_A + 8'd10)};
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            d = {1'b1, 4'(c - CH_UC_A + 8'd10)};
        end
        return d;
    endfunction

endpackage

[design/xcfp_scan.sv]
// Per-character line scanner: frame tracking, XOR sums, field capture and
// the checksum and decimal number parsers. Depends on xcfp_pkg.
module xcfp_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_char,
    input  logic                 i_last,
    output xcfp_pkg::t_line_state o_state
);

    typedef enum logic [1:0] {FR_IDLE, FR_BODY, FR_CLOSED, FR_BAD} t_frame;
    typedef enum logic [2:0] {HX_WS, HX_SIGN, HX_ZERO, HX_X, HX_DIG, HX_DONE} t_hex;
    typedef enum logic [1:0] {NM_WS, NM_SIGN, NM_DIG, NM_DONE} t_num;

    t_frame               r_frame, n_frame;
    logic [7:0]           r_body_xor, n_body_xor;
    logic [7:0]           r_payload_xor, n_payload_xor;
    logic [1:0]           r_comma_count, n_comma_count;
    xcfp_pkg::t_field     r_cmd_chars, n_cmd_chars;
    logic [3:0]           r_cmd_len, n_cmd_len;
    xcfp_pkg::t_field     r_val_chars, n_val_chars;
    logic [7:0]           r_val_len, n_val_len;
    logic [7:0]           r_lco, n_lco;
    logic [7:0]           r_hex_acc, n_hex_acc;
    t_hex                 r_hex_phase, n_hex_phase;
    logic                 r_hex_neg, n_hex_neg;
    logic [15:0]          r_num_acc, n_num_acc;
    t_num                 r_num_phase, n_num_phase;
    logic                 r_num_neg, n_num_neg;

    logic       c_space, c_sign, c_dig;
    logic [4:0] c_hex;
    logic [19:0] num_next;
    logic       num_take, hex_first;

    assign c_space   = xcfp_pkg::is_space(i_char);
    assign c_sign    = (i_char == xcfp_pkg::CH_PLUS) || (i_char == xcfp_pkg::CH_MINUS);
    assign c_dig     = (i_char >= xcfp_pkg::CH_0) && (i_char <= xcfp_pkg::CH_9);
    assign c_hex     = xcfp_pkg::hex_digit(i_char);
    // Decimal accumulate: acc * 10 + digit, built from shifts.
    assign num_next  = {1'b0, r_num_acc, 3'b000} + {3'b000, r_num_acc, 1'b0}
                     + {16'd0, 4'(i_char - xcfp_pkg::CH_0)};
    // A character past the leading whitespace and sign goes to the digit rules.
    assign num_take  = (r_num_phase == NM_WS && !c_space && !c_sign)
                     || r_num_phase == NM_SIGN || r_num_phase == NM_DIG;
    assign hex_first = (r_hex_phase == HX_WS && !c_space && !c_sign)
                     || r_hex_phase == HX_SIGN;

    // Next line state for the character being consumed.
    always_comb begin
        n_frame       = r_frame;
        n_body_xor    = r_body_xor;
        n_payload_xor = r_payload_xor;
        n_comma_count = r_comma_count;
        n_cmd_chars   = r_cmd_chars;
        n_cmd_len     = r_cmd_len;
        n_val_chars   = r_val_chars;
        n_val_len     = r_val_len;
        n_lco         = r_lco;
        n_hex_acc     = r_hex_acc;
        n_hex_phase   = r_hex_phase;
        n_hex_neg     = r_hex_neg;
        n_num_acc     = r_num_acc;
        n_num_phase   = r_num_phase;
        n_num_neg     = r_num_neg;
        if (i_step) begin
            case (r_frame)
                FR_IDLE: begin
                    if (i_char == xcfp_pkg::CH_LT) begin
                        n_frame = FR_BODY;
                    end else if (i_char == xcfp_pkg::CH_GT) begin
                        n_frame = FR_BAD;
                    end
                end
                FR_BODY: begin
                    if (i_char == xcfp_pkg::CH_GT) begin
                        n_frame = FR_CLOSED;
                    end else begin
                        n_body_xor = r_body_xor ^ i_char;
                        if (i_char == xcfp_pkg::CH_COMMA) begin
                            // Every comma marks a possible checksum start.
                            n_payload_xor = r_body_xor;
                            n_hex_acc     = 8'd0;
                            n_hex_phase   = HX_WS;
                            n_hex_neg     = 1'b0;
                            n_comma_count = (r_comma_count == 2'd0) ? 2'd1 : 2'd2;
                            if (r_comma_count != 2'd0) begin
                                n_lco = r_val_len;
                            end
                        end else if (r_comma_count == 2'd0) begin
                            // Command field character.
                            if (r_cmd_len < 4'(xcfp_pkg::FIELD_CHARS)
                                || xcfp_pkg::FIELD_CHARS > 15) begin
                                n_cmd_chars[xcfp_pkg::FIELD_IDX_W'(r_cmd_len)] = i_char;
                            end
                            if (r_cmd_len != 4'd15) begin
                                n_cmd_len = r_cmd_len + 4'd1;
                            end
                        end
                        if (r_comma_count != 2'd0) begin
                            // Value field character, commas after the first included.
                            if (r_val_len < 8'(xcfp_pkg::FIELD_CHARS)) begin
                                n_val_chars[xcfp_pkg::FIELD_IDX_W'(r_val_len)] = i_char;
                            end
                            if (r_val_len != 8'd255) begin
                                n_val_len = r_val_len + 8'd1;
                            end
                            // Decimal number parser.
                            if (r_num_phase == NM_WS && c_sign) begin
                                n_num_neg   = (i_char == xcfp_pkg::CH_MINUS);
                                n_num_phase = NM_SIGN;
                            end else if (num_take) begin
                                if (c_dig) begin
                                    n_num_acc   = (num_next > 20'd32768) ? 16'd32768
                                                                         : num_next[15:0];
                                    n_num_phase = NM_DIG;
                                end else begin
                                    n_num_phase = NM_DONE;
                                end
                            end
                            // Checksum parser, for characters other than commas.
                            if (i_char != xcfp_pkg::CH_COMMA) begin
                                if (r_hex_phase == HX_WS && c_space) begin
                                    n_hex_phase = HX_WS;
                                end else if (r_hex_phase == HX_WS && c_sign) begin
                                    n_hex_neg   = (i_char == xcfp_pkg::CH_MINUS);
                                    n_hex_phase = HX_SIGN;
                                end else if (hex_first) begin
                                    if (i_char == xcfp_pkg::CH_0) begin
                                        n_hex_phase = HX_ZERO;
                                    end else if (c_hex[4]) begin
                                        n_hex_acc   = {4'd0, c_hex[3:0]};
                                        n_hex_phase = HX_DIG;
                                    end else begin
                                        n_hex_phase = HX_DONE;
                                    end
                                end else if (r_hex_phase == HX_ZERO
                                             && (i_char == xcfp_pkg::CH_LC_X
                                                 || i_char == xcfp_pkg::CH_UC_X)) begin
                                    n_hex_phase = HX_X;
                                end else if (r_hex_phase == HX_ZERO || r_hex_phase == HX_X) begin
                                    if (c_hex[4]) begin
                                        n_hex_acc   = {4'd0, c_hex[3:0]};
                                        n_hex_phase = HX_DIG;
                                    end else begin
                                        n_hex_phase = HX_DONE;
                                    end
                                end else if (r_hex_phase == HX_DIG) begin
                                    if (c_hex[4]) begin
                                        n_hex_acc = {r_hex_acc[3:0], c_hex[3:0]};
                                    end else begin
                                        n_hex_phase = HX_DONE;
                                    end
                                end
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            // A line's last character resets all line state but the field characters.
            if (i_last) begin
                n_frame       = FR_IDLE;
                n_body_xor    = 8'd0;
                n_payload_xor = 8'd0;
                n_comma_count = 2'd0;
                n_cmd_len     = 4'd0;
                n_val_len     = 8'd0;
                n_lco         = 8'd0;
                n_hex_acc     = 8'd0;
                n_hex_phase   = HX_WS;
                n_hex_neg     = 1'b0;
                n_num_acc     = 16'd0;
                n_num_phase   = NM_WS;
                n_num_neg     = 1'b0;
            end
        end
    end

    // Line state registers; the stored field characters need no reset.
    always_ff @(posedge i_clk) begin
        r_cmd_chars <= n_cmd_chars;
        r_val_chars <= n_val_chars;
        if (!i_rst_n) begin
            r_frame       <= FR_IDLE;
            r_body_xor    <= 8'd0;
            r_payload_xor <= 8'd0;
            r_comma_count <= 2'd0;
            r_cmd_len     <= 4'd0;
            r_val_len     <= 8'd0;
            r_lco         <= 8'd0;
            r_hex_acc     <= 8'd0;
            r_hex_phase   <= HX_WS;
            r_hex_neg     <= 1'b0;
            r_num_acc     <= 16'd0;
            r_num_phase   <= NM_WS;
            r_num_neg     <= 1'b0;
        end else begin
            r_frame       <= n_frame;
            r_body_xor    <= n_body_xor;
            r_payload_xor <= n_payload_xor;
            r_comma_count <= n_comma_count;
            r_cmd_len     <= n_cmd_len;
            r_val_len     <= n_val_len;
            r_lco         <= n_lco;
            r_hex_acc     <= n_hex_acc;
            r_hex_phase   <= n_hex_phase;
            r_hex_neg     <= n_hex_neg;
            r_num_acc     <= n_num_acc;
            r_num_phase   <= n_num_phase;
            r_num_neg     <= n_num_neg;
        end
    end

    // State seen by the verdict logic.
    always_comb begin
        o_state.in_body     = (r_frame == FR_BODY);
        o_state.closed      = (r_frame == FR_CLOSED);
        o_state.comma_count = r_comma_count;
        o_state.payload_xor = r_payload_xor;
        o_state.hex_acc     = r_hex_acc;
        o_state.hex_neg     = r_hex_neg;
        o_state.cmd_len     = r_cmd_len;
        o_state.cmd_chars   = r_cmd_chars;
        o_state.val_len     = r_lco;
        o_state.val_chars   = r_val_chars;
        o_state.num_acc     = r_num_acc;
        o_state.num_neg     = r_num_neg;
    end

endmodule

[design/xcfp_verdict.sv]
// Line verdict: frame, comma and checksum checks, keyword matching and the
// saturated wrist value. Combinational; depends on xcfp_pkg.
module xcfp_verdict (
    input  xcfp_pkg::t_line_state i_state,
    input  logic [7:0]            i_char,
    output xcfp_pkg::t_out_item   o_result
);

    logic       closed;
    logic [7:0] got;
    logic       is_pose, is_wrist, is_grip, is_halt;
    logic [7:0] cmd_len8;
    logic [3:0] cmd;
    logic [15:0] wrist_val;

    // A closing bracket never changes the body, so the stored state is final.
    assign closed   = i_state.closed || (i_state.in_body && i_char == xcfp_pkg::CH_GT);
    assign got      = i_state.hex_neg ? (8'd0 - i_state.hex_acc) : i_state.hex_acc;
    assign cmd_len8 = {4'd0, i_state.cmd_len};

    assign is_pose  = xcfp_pkg::kw_match(i_state.cmd_chars, cmd_len8,
                                         xcfp_pkg::KW_POSE, xcfp_pkg::KW_LEN4);
    assign is_wrist = xcfp_pkg::kw_match(i_state.cmd_chars, cmd_len8,
                                         xcfp_pkg::KW_WRIST, xcfp_pkg::KW_LEN5);
    assign is_grip  = xcfp_pkg::kw_match(i_state.cmd_chars, cmd_len8,
                                         xcfp_pkg::KW_GRIP, xcfp_pkg::KW_LEN4);
    assign is_halt  = xcfp_pkg::kw_match(i_state.cmd_chars, cmd_len8,
                                         xcfp_pkg::KW_STOP, xcfp_pkg::KW_LEN4);

    // Clamp the wrist angle to the signed 16-bit range.
    assign wrist_val = i_state.num_neg ? (16'd0 - i_state.num_acc)
                     : (i_state.num_acc > 16'd32767) ? 16'd32767 : i_state.num_acc;

    // Command decode from the command and value keywords.
    always_comb begin
        cmd = xcfp_pkg::CMD_NONE;
        if (is_pose) begin
            if (xcfp_pkg::kw_match(i_state.val_chars, i_state.val_len,
                                   xcfp_pkg::KW_HOME, xcfp_pkg::KW_LEN4)) begin
                cmd = xcfp_pkg::CMD_HOME;
            end else if (xcfp_pkg::kw_match(i_state.val_chars, i_state.val_len,
                                            xcfp_pkg::KW_READY, xcfp_pkg::KW_LEN5)) begin
                cmd = xcfp_pkg::CMD_READY;
            end else if (xcfp_pkg::kw_match(i_state.val_chars, i_state.val_len,
                                            xcfp_pkg::KW_DROP, xcfp_pkg::KW_LEN4)) begin
                cmd = xcfp_pkg::CMD_DROP;
            end
        end else if (is_wrist) begin
            cmd = xcfp_pkg::CMD_WRIST;
        end else if (is_grip) begin
            if (xcfp_pkg::kw_match(i_state.val_chars, i_state.val_len,
                                   xcfp_pkg::KW_SOFT, xcfp_pkg::KW_LEN4)) begin
                cmd = xcfp_pkg::CMD_SOFT;
            end else if (xcfp_pkg::kw_match(i_state.val_chars, i_state.val_len,
                                            xcfp_pkg::KW_HARD, xcfp_pkg::KW_LEN4)) begin
                cmd = xcfp_pkg::CMD_HARD;
            end else if (xcfp_pkg::kw_match(i_state.val_chars, i_state.val_len,
                                            xcfp_pkg::KW_OPEN, xcfp_pkg::KW_LEN4)) begin
                cmd = xcfp_pkg::CMD_OPEN;
            end
        end else if (is_halt) begin
            cmd = xcfp_pkg::CMD_STOP;
        end
    end

    // Checks in priority order; command and value only count on a clean line.
    always_comb begin
        o_result.status  = xcfp_pkg::ST_OK;
        o_result.command = xcfp_pkg::CMD_NONE;
        o_result.value   = 16'sd0;
        if (!closed) begin
            o_result.status = xcfp_pkg::ST_BAD_FRAME;
        end else if (i_state.comma_count != 2'd2) begin
            o_result.status = xcfp_pkg::ST_NO_COMMAS;
        end else if (got != i_state.payload_xor) begin
            o_result.status = xcfp_pkg::ST_CHECKSUM;
        end else if (cmd == xcfp_pkg::CMD_NONE) begin
            o_result.status = xcfp_pkg::ST_UNKNOWN;
        end else begin
            o_result.command = cmd;
            if (cmd == xcfp_pkg::CMD_WRIST) begin
                o_result.value = signed'(wrist_val);
            end
        end
    end

endmodule

[design/xor_checked_command_frame_parser_top.sv]
// Top level of the framed command line checker: input register, scanner,
// verdict logic and result register. Depends on xcfp_pkg, xcfp_scan, xcfp_verdict.
//
// The block takes one character per item, one item per clock cycle; items other
// than a line end keep that rate while a finished result waits in the output
// register. Each item is first captured in an input register; from there the
// scanner folds it into the line state and, for the item flagged as line end,
// the verdict is written to the result register. Only a line-end item waits
// for a full result register, and then input ready drops until the result is
// taken. After a verdict all line state but the stored field characters returns
// to its reset value, so the next line may start at once.
module xor_checked_command_frame_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  xcfp_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output xcfp_pkg::t_out_item o_out_item
);

    logic                  r_in_valid;
    xcfp_pkg::t_in_item    r_in_item;
    logic                  r_out_valid;
    xcfp_pkg::t_out_item   r_out_item;
    logic                  out_free, advance;
    xcfp_pkg::t_line_state line_state;
    xcfp_pkg::t_out_item   verdict;

    // The held item moves on unless it needs the result register and that is full.
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && (!r_in_item.line_end || out_free);
    assign o_in_ready = !r_in_valid || advance;

    xcfp_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_char  (r_in_item.char_in),
        .i_last  (r_in_item.line_end),
        .o_state (line_state)
    );

    xcfp_verdict u_verdict (
        .i_state  (line_state),
        .i_char   (r_in_item.char_in),
        .o_result (verdict)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (advance && r_in_item.line_end) begin
            r_out_item <= verdict;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_item.line_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
